// ===== src/assert_macros.svh =====
// Assertion macros shared by the deframer RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `ASSERT_AT(label, clk, rst_n, !(cond), msg)

`endif

// ===== src/mphd_pkg.sv =====
// Package for the mesh packet header deframer: field codes, flag bit
// positions and the words passed between the pipeline stages. No dependencies.
package mphd_pkg;

    // Width and ceiling of the per-field byte offset.
    localparam int                     OFFSET_BITS = 11;
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX  = 11'd2047;

    // Bit positions inside the flags byte.
    localparam int FLAG_HEADER_BIT    = 6;
    localparam int FLAG_CONTEXT_BIT   = 5;
    localparam int FLAG_TRANSPORT_BIT = 4;
    localparam int FLAG_DEST_HI       = 3;
    localparam int FLAG_DEST_LO       = 2;
    localparam int FLAG_PACKET_HI     = 1;
    localparam int FLAG_PACKET_LO     = 0;

    // The flags byte enters the hash with its high nibble cleared.
    localparam logic [7:0] HASH_FLAGS_MASK = 8'h0F;

    // Field a byte belongs to.
    typedef enum logic [2:0] {
        FK_FLAGS     = 3'd0,
        FK_HOPS      = 3'd1,
        FK_TRANSPORT = 3'd2,
        FK_DEST      = 3'd3,
        FK_CONTEXT   = 3'd4,
        FK_PAYLOAD   = 3'd5
    } t_field_kind;

    // Word held in the input register: the byte and the packet's flags.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic [7:0] flags;
    } t_stage_word;

    // Word held in the result register.
    typedef struct packed {
        logic [7:0]             byte_value;
        t_field_kind            field_kind;
        logic [OFFSET_BITS-1:0] field_offset;
        logic                   hash_valid;
        logic [7:0]             hash_byte;
        logic                   two_address_header;
        logic                   context_flag_bit;
        logic                   transport_mode;
        logic [1:0]             destination_kind;
        logic [1:0]             packet_kind;
        logic                   packet_end;
        logic                   status;
    } t_result;

endpackage

// ===== src/mphd_in_if.sv =====
// Input channel of the deframer: one raw packet byte per word.
// Depends on nothing.
interface mphd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== src/mphd_out_if.sv =====
// Output channel of the deframer: one tagged byte per word.
// Depends on nothing.
interface mphd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_value;
    logic [2:0]  field_kind;
    logic [10:0] field_offset;
    logic        hash_valid;
    logic [7:0]  hash_byte;
    logic        two_address_header;
    logic        context_flag_bit;
    logic        transport_mode;
    logic [1:0]  destination_kind;
    logic [1:0]  packet_kind;
    logic        packet_end;
    logic        status;

    modport source (
        output valid, input ready,
        output byte_value, output field_kind, output field_offset,
        output hash_valid, output hash_byte, output two_address_header,
        output context_flag_bit, output transport_mode, output destination_kind,
        output packet_kind, output packet_end, output status
    );
    modport sink (
        input valid, output ready,
        input byte_value, input field_kind, input field_offset,
        input hash_valid, input hash_byte, input two_address_header,
        input context_flag_bit, input transport_mode, input destination_kind,
        input packet_kind, input packet_end, input status
    );
endinterface

// ===== src/mphd_capture.sv =====
// Input stage of the deframer: accepts bytes, tracks the byte position and
// the flags byte of the current packet. Depends on mphd_pkg and mphd_in_if.
module mphd_capture import mphd_pkg::*; #(
    parameter int MAX_PACKET_BYTES = 2048,
    parameter int POS_BITS         = $clog2(MAX_PACKET_BYTES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mphd_in_if.sink           i_in,
    input  logic              i_take,
    output logic              o_valid,
    output t_stage_word       o_word,
    output logic [POS_BITS-1:0] o_pos
);

    localparam logic [POS_BITS-1:0] POS_LAST = POS_BITS'(MAX_PACKET_BYTES - 1);

    logic                r_valid;
    t_stage_word         r_word;
    logic [POS_BITS-1:0] r_pos;
    logic [POS_BITS-1:0] r_position;
    logic [7:0]          r_held_flags;

    logic                accept;
    logic                first_byte;
    logic [7:0]          n_flags;
    logic [POS_BITS-1:0] n_position;

    // The stage takes a new word when empty or when its word moves on.
    assign i_in.ready = !r_valid || i_take;
    assign accept     = i_in.valid && i_in.ready;
    assign first_byte = (r_position == '0);

    // The flags byte is the data itself at the start of a packet.
    assign n_flags = first_byte ? i_in.data_byte : r_held_flags;

    // Position restarts after the last byte and sticks at its ceiling.
    always_comb begin
        if (i_in.last_byte) begin
            n_position = '0;
        end else if (r_position < POS_LAST) begin
            n_position = r_position + POS_BITS'(1);
        end else begin
            n_position = r_position;
        end
    end

    // Packet state and the valid flag of the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_position   <= '0;
            r_held_flags <= '0;
        end else begin
            if (accept) begin
                r_valid      <= 1'b1;
                r_position   <= n_position;
                r_held_flags <= n_flags;
            end else if (i_take) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Payload of the input register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word.data_byte <= i_in.data_byte;
            r_word.last_byte <= i_in.last_byte;
            r_word.flags     <= n_flags;
            r_pos            <= r_position;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;
    assign o_pos   = r_pos;

endmodule

// ===== src/mphd_tag.sv =====
// Tagging stage of the deframer: classifies a byte by position and flags and
// holds the result register. Depends on mphd_pkg and mphd_out_if.
module mphd_tag import mphd_pkg::*; #(
    parameter int DEST_HASH_BYTES  = 16,
    parameter int MAX_PACKET_BYTES = 2048,
    parameter int POS_BITS         = $clog2(MAX_PACKET_BYTES)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  t_stage_word         i_word,
    input  logic [POS_BITS-1:0] i_pos,
    output logic                o_take,
    mphd_out_if.source          o_out
);

    // Working width: room for the position, the header bounds and the offset.
    localparam int OW = (POS_BITS + 1 > OFFSET_BITS) ? POS_BITS + 1 : OFFSET_BITS;

    localparam logic [OW-1:0] HOPS_POS  = OW'(1);
    localparam logic [OW-1:0] TID_START = OW'(2);
    localparam logic [OW-1:0] DEST_TWO  = OW'(2 + DEST_HASH_BYTES);
    localparam logic [OW-1:0] CTX_ONE   = OW'(2 + DEST_HASH_BYTES);
    localparam logic [OW-1:0] CTX_TWO   = OW'(2 + 2 * DEST_HASH_BYTES);
    localparam logic [OW-1:0] PAY_ONE   = OW'(3 + DEST_HASH_BYTES);
    localparam logic [OW-1:0] PAY_TWO   = OW'(3 + 2 * DEST_HASH_BYTES);

    logic        r_valid;
    t_result     r_result;
    t_result     n_result;

    logic [OW-1:0] pos_x;
    logic          two;
    logic [OW-1:0] dest_start;
    logic [OW-1:0] ctx_pos;
    logic [OW-1:0] pay_start;
    logic [OW-1:0] base;
    logic [OW-1:0] diff;
    t_field_kind   kind;

    assign pos_x = {{(OW - POS_BITS){1'b0}}, i_pos};
    assign two   = i_word.flags[FLAG_HEADER_BIT];

    // Field bounds; a two-address header inserts the transport id first,
    // so the destination starts at 18 at default sizes.
    assign dest_start = two ? DEST_TWO : TID_START;
    assign ctx_pos    = two ? CTX_TWO  : CTX_ONE;
    assign pay_start  = two ? PAY_TWO  : PAY_ONE;

    // Field kind and the start the offset is measured from.
    always_comb begin
        if (pos_x == '0) begin
            kind = FK_FLAGS;
            base = pos_x;
        end else if (pos_x == HOPS_POS) begin
            kind = FK_HOPS;
            base = pos_x;
        end else if (pos_x < dest_start) begin
            kind = FK_TRANSPORT;
            base = TID_START;
        end else if (pos_x < ctx_pos) begin
            kind = FK_DEST;
            base = dest_start;
        end else if (pos_x == ctx_pos) begin
            kind = FK_CONTEXT;
            base = pos_x;
        end else begin
            kind = FK_PAYLOAD;
            base = pay_start;
        end
    end

    assign diff = pos_x - base;

    // Result word for the byte in the input register.
    always_comb begin
        n_result.byte_value         = i_word.data_byte;
        n_result.field_kind         = kind;
        n_result.field_offset       = (diff > OW'(OFFSET_MAX)) ? OFFSET_MAX
                                                               : diff[OFFSET_BITS-1:0];
        n_result.two_address_header = two;
        n_result.context_flag_bit   = i_word.flags[FLAG_CONTEXT_BIT];
        n_result.transport_mode     = i_word.flags[FLAG_TRANSPORT_BIT];
        n_result.destination_kind   = i_word.flags[FLAG_DEST_HI:FLAG_DEST_LO];
        n_result.packet_kind        = i_word.flags[FLAG_PACKET_HI:FLAG_PACKET_LO];
        n_result.packet_end         = i_word.last_byte;
        // The packet is short when it ends before its context byte.
        n_result.status             = i_word.last_byte && (pos_x < ctx_pos);
        // Hash input: masked flags byte, then everything from the destination on.
        if (pos_x == '0) begin
            n_result.hash_valid = 1'b1;
            n_result.hash_byte  = i_word.data_byte & HASH_FLAGS_MASK;
        end else if (pos_x >= dest_start) begin
            n_result.hash_valid = 1'b1;
            n_result.hash_byte  = i_word.data_byte;
        end else begin
            n_result.hash_valid = 1'b0;
            n_result.hash_byte  = '0;
        end
    end

    // The result register loads when empty or when its word is taken.
    assign o_take = i_valid && (!r_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_result <= n_result;
        end
    end

    // Drive the output channel.
    assign o_out.valid              = r_valid;
    assign o_out.byte_value         = r_result.byte_value;
    assign o_out.field_kind         = r_result.field_kind;
    assign o_out.field_offset       = r_result.field_offset;
    assign o_out.hash_valid         = r_result.hash_valid;
    assign o_out.hash_byte          = r_result.hash_byte;
    assign o_out.two_address_header = r_result.two_address_header;
    assign o_out.context_flag_bit   = r_result.context_flag_bit;
    assign o_out.transport_mode     = r_result.transport_mode;
    assign o_out.destination_kind   = r_result.destination_kind;
    assign o_out.packet_kind        = r_result.packet_kind;
    assign o_out.packet_end         = r_result.packet_end;
    assign o_out.status             = r_result.status;

endmodule

// ===== src/mesh_packet_header_deframer.sv =====
// Channel   Dir  Word carries
// i_in      in   data_byte, last_byte
// o_out     out  tagged byte, field kind and offset, hash byte, flag fields, status
//
// One byte per cycle while o_out.ready stays high: a byte accepted into the input
// register loads the result register from there and then can leave on o_out.
// While a result waits, the input register still takes one more word; after that
// i_in.ready stays low until the result word is taken.
// Synchronous active-low reset empties both registers and restarts the packet.
// Top level of the mesh packet header deframer; uses mphd_pkg, the channel
// interfaces, mphd_capture, mphd_tag and assert_macros.svh.
`include "assert_macros.svh"

module mesh_packet_header_deframer import mphd_pkg::*; #(
    parameter int DEST_HASH_BYTES  = 16,
    parameter int MAX_PACKET_BYTES = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mphd_in_if.sink     i_in,
    mphd_out_if.source  o_out
);

    localparam int POS_BITS = $clog2(MAX_PACKET_BYTES);

    logic                stage_valid;
    logic                stage_take;
    t_stage_word         stage_word;
    logic [POS_BITS-1:0] stage_pos;

    // Input register with the packet position and flags.
    mphd_capture #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
        .POS_BITS         (POS_BITS)
    ) u_capture (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (stage_take),
        .o_valid (stage_valid),
        .o_word  (stage_word),
        .o_pos   (stage_pos)
    );

    // Classification and result register.
    mphd_tag #(
        .DEST_HASH_BYTES  (DEST_HASH_BYTES),
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
        .POS_BITS         (POS_BITS)
    ) u_tag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stage_valid),
        .i_word  (stage_word),
        .i_pos   (stage_pos),
        .o_take  (stage_take),
        .o_out   (o_out)
    );

    // A short-packet status only appears on the last byte.
    `ASSERT_AT(a_status_on_end, i_clk, i_rst_n,
        o_out.valid && o_out.status |-> o_out.packet_end, "status set off packet end")
    // Bytes outside the hash carry a zero hash byte.
    `ASSERT_AT(a_hash_idle_zero, i_clk, i_rst_n,
        o_out.valid && !o_out.hash_valid |-> o_out.hash_byte == 8'd0, "hash byte not zero")
    // A transport id only exists in a two-address header.
    `ASSERT_NEVER(a_tid_two_addr, i_clk, i_rst_n,
        o_out.valid && (o_out.field_kind == FK_TRANSPORT) && !o_out.two_address_header,
        "transport id in one-address header")
    // A word taken by the tag stage leaves the input register or is replaced.
    `ASSERT_AT(a_stage_drain, i_clk, i_rst_n,
        stage_take && !(i_in.valid && i_in.ready) |=> !stage_valid,
        "input register kept a moved word")

endmodule

// ===== tb/mphd_checker.sv =====
// Checker for the mesh packet header deframer: tags each accepted byte the way
// the block should and compares every result word field by field.
// Depends on mphd_pkg, mphd_in_if and mphd_out_if.
module mphd_checker import mphd_pkg::*; #(
    parameter int DEST_HASH_BYTES  = 16,
    parameter int MAX_PACKET_BYTES = 2048
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mphd_in_if   i_in_mon,
    mphd_out_if  i_out_mon,
    output int   o_fail_count,
    output int   o_outstanding
);

    // Tags expected on the output, oldest first.
    t_result    pending_tags[$];

    // Packet parse state: position of the next byte and the packet's flags.
    int         byte_pos;
    logic [7:0] packet_flags;

    // Clamps an offset within a field to the widest value the port can carry.
    function automatic logic [OFFSET_BITS-1:0] clip_offset(input int d);
        if (d > int'(OFFSET_MAX)) begin
            return OFFSET_MAX;
        end
        return d[OFFSET_BITS-1:0];
    endfunction

    // Works out the tag for one byte and advances the packet position.
    task automatic tag_byte(input logic [7:0] b, input logic last, output t_result r);
        int   pos;
        int   dest_start;
        int   ctx_pos;
        int   need;
        logic two;
        pos = byte_pos;
        if (pos == 0) begin
            packet_flags = b;
        end
        two        = packet_flags[FLAG_HEADER_BIT];
        dest_start = two ? 2 + DEST_HASH_BYTES : 2;
        ctx_pos    = dest_start + DEST_HASH_BYTES;

        r = '0;
        r.byte_value = b;
        if (pos == 0) begin
            r.field_kind = FK_FLAGS;
        end else if (pos == 1) begin
            r.field_kind = FK_HOPS;
        end else if (pos < dest_start) begin
            r.field_kind   = FK_TRANSPORT;
            r.field_offset = clip_offset(pos - 2);
        end else if (pos < ctx_pos) begin
            r.field_kind   = FK_DEST;
            r.field_offset = clip_offset(pos - dest_start);
        end else if (pos == ctx_pos) begin
            r.field_kind = FK_CONTEXT;
        end else begin
            r.field_kind   = FK_PAYLOAD;
            r.field_offset = clip_offset(pos - ctx_pos - 1);
        end

        // The hash takes the masked flags byte, then everything past the
        // hops byte and the transport id.
        if (pos == 0) begin
            r.hash_valid = 1'b1;
            r.hash_byte  = b & HASH_FLAGS_MASK;
        end else if (pos >= dest_start) begin
            r.hash_valid = 1'b1;
            r.hash_byte  = b;
        end

        r.two_address_header = two;
        r.context_flag_bit   = packet_flags[FLAG_CONTEXT_BIT];
        r.transport_mode     = packet_flags[FLAG_TRANSPORT_BIT];
        r.destination_kind   = packet_flags[FLAG_DEST_HI:FLAG_DEST_LO];
        r.packet_kind        = packet_flags[FLAG_PACKET_HI:FLAG_PACKET_LO];
        r.packet_end         = last;

        // The position stops at the last slot of an overlong packet.
        if (last) begin
            need     = two ? 3 + 2 * DEST_HASH_BYTES : 3 + DEST_HASH_BYTES;
            r.status = (pos + 1 < need);
            byte_pos = 0;
        end else if (pos < MAX_PACKET_BYTES - 1) begin
            byte_pos = pos + 1;
        end
    endtask

    // Reports one field that differs from its expected value.
    task automatic check_field(input string fname, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
            o_fail_count++;
        end
    endtask

    // Watch both channels; results are compared before new bytes are tagged.
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            pending_tags.delete();
            byte_pos      = 0;
            packet_flags  = '0;
            o_outstanding = 0;
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.byte_value         = i_out_mon.byte_value;
                got.field_kind         = t_field_kind'(i_out_mon.field_kind);
                got.field_offset       = i_out_mon.field_offset;
                got.hash_valid         = i_out_mon.hash_valid;
                got.hash_byte          = i_out_mon.hash_byte;
                got.two_address_header = i_out_mon.two_address_header;
                got.context_flag_bit   = i_out_mon.context_flag_bit;
                got.transport_mode     = i_out_mon.transport_mode;
                got.destination_kind   = i_out_mon.destination_kind;
                got.packet_kind        = i_out_mon.packet_kind;
                got.packet_end         = i_out_mon.packet_end;
                got.status             = i_out_mon.status;
                if (pending_tags.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual byte %0h",
                             $time, got.byte_value);
                    o_fail_count++;
                end else begin
                    want = pending_tags.pop_front();
                    check_field("byte_value", 16'(want.byte_value), 16'(got.byte_value));
                    check_field("field_kind", 16'(want.field_kind), 16'(got.field_kind));
                    check_field("field_offset", 16'(want.field_offset),
                                16'(got.field_offset));
                    check_field("hash_valid", 16'(want.hash_valid), 16'(got.hash_valid));
                    check_field("hash_byte", 16'(want.hash_byte), 16'(got.hash_byte));
                    check_field("two_address_header", 16'(want.two_address_header),
                                16'(got.two_address_header));
                    check_field("context_flag_bit", 16'(want.context_flag_bit),
                                16'(got.context_flag_bit));
                    check_field("transport_mode", 16'(want.transport_mode),
                                16'(got.transport_mode));
                    check_field("destination_kind", 16'(want.destination_kind),
                                16'(got.destination_kind));
                    check_field("packet_kind", 16'(want.packet_kind),
                                16'(got.packet_kind));
                    check_field("packet_end", 16'(want.packet_end), 16'(got.packet_end));
                    check_field("status", 16'(want.status), 16'(got.status));
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                tag_byte(i_in_mon.data_byte, i_in_mon.last_byte, want);
                pending_tags.insert(pending_tags.size(), want);
            end
            o_outstanding = pending_tags.size();
        end
    end

endmodule

// ===== tb/tb_mesh_packet_header_deframer.sv =====
// Testbench top for the mesh packet header deframer: drives packets byte by
// byte with random idling and gives the verdict. Depends on mphd_pkg, the
// channel interfaces, mphd_checker and the block itself.
module tb_mesh_packet_header_deframer;
    import mphd_pkg::*;

    localparam int DEST_BYTES    = 16;
    localparam int MAX_BYTES     = 2048;
    localparam int RANDOM_BYTES  = 1050;
    localparam int PHASE_BYTES   = 263;
    localparam int LONG_HOLD     = 50;
    localparam int DRAIN_CYCLES  = 10;

    logic i_clk;
    logic i_rst_n;

    mphd_in_if  in_ch ();
    mphd_out_if out_ch ();

    int fail_count;
    int outstanding;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_req;
    int hold_done;
    int bytes_sent;

    mesh_packet_header_deframer #(
        .DEST_HASH_BYTES  (DEST_BYTES),
        .MAX_PACKET_BYTES (MAX_BYTES)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    mphd_checker #(
        .DEST_HASH_BYTES  (DEST_BYTES),
        .MAX_PACKET_BYTES (MAX_BYTES)
    ) i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_mon      (in_ch),
        .i_out_mon     (out_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Safety net in case the block hangs.
    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: random stalls, plus long hold-offs on request.
    initial begin
        out_ch.ready = 1'b0;
        hold_done    = 0;
        forever begin
            @(posedge i_clk);
            if (hold_done < hold_req) begin
                hold_done++;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge i_clk);
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offers one word and waits until the block takes it.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.last_byte <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Sends a packet with the given flags byte and random body bytes.
    task automatic send_packet(input logic [7:0] flags, input int len);
        send_byte(flags, len == 1);
        for (int i = 1; i < len; i++) begin
            send_byte(8'($urandom_range(255)), i == len - 1);
        end
    endtask

    // Stimulus: directed packets, then random packets across idling phases.
    initial begin
        logic [7:0] flags;
        int         need;
        int         pick;
        int         len;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.last_byte = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_req        = 0;
        bytes_sent      = 0;
        i_rst_n         = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // One-byte packets with every flag bit set and with none set.
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        // A two-address header cut short, body bytes at both extremes.
        send_byte(8'h40, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        // A one-address packet of exactly the minimum length.
        send_byte(8'h3F, 1'b0);
        for (int i = 1; i < 3 + DEST_BYTES; i++) begin
            send_byte((i % 2) ? 8'hFF : 8'h00, i == 2 + DEST_BYTES);
        end

        // Random packets, mostly well formed, some cut short or at the
        // length boundary. The idling pattern changes every few hundred bytes.
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            case ((bytes_sent / PHASE_BYTES) % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            // Hold the output off while the sender keeps pushing.
            if (bytes_sent % PHASE_BYTES < 40 && hold_req <= bytes_sent / PHASE_BYTES) begin
                hold_req++;
            end
            flags = 8'($urandom_range(255));
            need  = flags[FLAG_HEADER_BIT] ? 3 + 2 * DEST_BYTES : 3 + DEST_BYTES;
            pick  = $urandom_range(99);
            if (pick < 8) begin
                len = $urandom_range(3, 1);
            end else if (pick < 22) begin
                len = need - 1 + $urandom_range(2);
            end else if (pick < 85) begin
                len = need + $urandom_range(14);
            end else begin
                len = $urandom_range(need - 1, 4);
            end
            send_packet(flags, len);
        end

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
